### rtl/assert_macros.svh
// assertion macros used by the checker file ses_chk
// no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// clocked check that also holds during reset
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

### rtl/ses_pkg.sv
// ses_pkg: widths, constants, codes and control types of the encoder speed estimator
// used by every rtl file of the block but ses_ram and assert_macros.svh; no dependencies
`timescale 1ns / 1ps

package ses_pkg;

    localparam int WORD_W      = 16;
    localparam int ANGLE_OUT_W = 14;
    localparam int SPEED_W     = 22;
    localparam int GAIN_W      = 24;
    localparam int FLEN_W      = 6;
    localparam int STATUS_W    = 2;
    localparam int SUM_W       = 28;
    localparam int WIDE_W      = 48;
    localparam int FRAC_SHIFT  = 16;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 24;

    localparam int DEF_MAX_SLOTS  = 32;
    localparam int DEF_ANGLE_BITS = 14;

    localparam int SPEED_MAX = 2097151;
    localparam int SPEED_MIN = -2097152;

    localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(9047787);
    localparam int                FLEN_RESET = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_FLEN = CFG_IDX_W'(1);

    typedef enum logic [STATUS_W-1:0] {
        ST_SPEED  = 2'd0,
        ST_PARITY = 2'd1,
        ST_FIRST  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_MUL,
        S_SUB,
        S_ADD,
        S_ABS,
        S_DIV,
        S_NEG,
        S_DONE
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    typedef enum logic [2:0] {
        SEL_NONE,
        SEL_SLOT,
        SEL_SPEED,
        SEL_ABS,
        SEL_DIV,
        SEL_NEG
    } alu_sel_t;

    // flags from the datapath to the sequencer
    typedef struct packed {
        logic in_valid;
        logic skip_math;
        logic count_zero;
        logic div_last;
        logic out_free;
    } fsm_in_t;

    // strobes from the sequencer to the datapath
    typedef struct packed {
        logic     ready;
        logic     ld_prod;
        logic     upd_sub;
        logic     upd_add;
        logic     ld_abs;
        logic     div_step;
        logic     ld_avg;
        logic     ld_out;
        alu_sel_t sel;
    } ctrl_t;

endpackage

### rtl/ses_if.sv
// ses_in_if and ses_out_if: valid/ready channels of the encoder speed estimator
// depends on ses_pkg
`timescale 1ns / 1ps

interface ses_in_if import ses_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] raw_word;

    modport source (output valid, output raw_word, input ready);
    modport sink   (input valid, input raw_word, output ready);
endinterface

interface ses_out_if import ses_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic [STATUS_W-1:0]        status;
    logic [ANGLE_OUT_W-1:0]     angle;
    logic signed [SPEED_W-1:0]  speed_q5;
    logic signed [SPEED_W-1:0]  filtered_speed_q5;

    modport source (output valid, output status, output angle, output speed_q5,
                    output filtered_speed_q5, input ready);
    modport sink   (input valid, input status, input angle, input speed_q5,
                    input filtered_speed_q5, output ready);
endinterface

### rtl/ses_ram.sv
// ses_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`timescale 1ns / 1ps

module ses_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/ses_alu.sv
// ses_alu: the shared adder/subtractor for sum update, abs, divide steps and sign fix
// depends on ses_pkg
`timescale 1ns / 1ps

module ses_alu import ses_pkg::*; #(
    parameter int WIDTH = SUM_W + 1
) (
    input  logic [WIDTH-1:0] a,
    input  logic [WIDTH-1:0] b,
    input  alu_op_t          op,
    output logic [WIDTH-1:0] y
);

    always_comb
    begin
        case (op)
            ALU_ADD: y = a + b;
            ALU_SUB: y = a - b;
            default: y = a + b;
        endcase
    end

endmodule

### rtl/ses_ctrl.sv
// ses_ctrl: sequencer that steps one word through multiply, sum update and divide
// depends on ses_pkg
`timescale 1ns / 1ps

module ses_ctrl import ses_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  fsm_in_t flags,
    output ctrl_t   ctrl
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (flags.in_valid)
                begin
                    state_next = flags.skip_math ? S_DONE : S_MUL;
                end
            end
            S_MUL: state_next = S_SUB;
            S_SUB: state_next = S_ADD;
            S_ADD: state_next = S_ABS;
            S_ABS: state_next = flags.count_zero ? S_DONE : S_DIV;
            S_DIV:
            begin
                if (flags.div_last)
                begin
                    state_next = S_NEG;
                end
            end
            S_NEG: state_next = S_DONE;
            S_DONE:
            begin
                if (flags.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb
    begin
        ctrl = '0;
        ctrl.sel = SEL_NONE;
        case (state_reg)
            S_IDLE: ctrl.ready = 1'b1;
            S_MUL:  ctrl.ld_prod = 1'b1;
            S_SUB:
            begin
                ctrl.upd_sub = 1'b1;
                ctrl.sel     = SEL_SLOT;
            end
            S_ADD:
            begin
                ctrl.upd_add = 1'b1;
                ctrl.sel     = SEL_SPEED;
            end
            S_ABS:
            begin
                ctrl.ld_abs = !flags.count_zero;
                ctrl.sel    = SEL_ABS;
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                ctrl.sel      = SEL_DIV;
            end
            S_NEG:
            begin
                ctrl.ld_avg = 1'b1;
                ctrl.sel    = SEL_NEG;
            end
            S_DONE: ctrl.ld_out = flags.out_free;
            default: ctrl.ready = 1'b0;
        endcase
    end

endmodule

### rtl/encoder_speed_estimator.sv
// encoder speed estimator: parity check, angle difference, gain scaling, moving average
// a speed word runs through multiply, sum update, abs, 28 divide steps on the shared
// adder, sign fix; parity errors and first samples skip the math; empty filter skips
// the divide; one word at a time, a new one is taken only after the result is loaded
// reset: async active low; gain 9047787, filter length 20, all filter state cleared
// depends on ses_pkg, ses_if, ses_ram, ses_alu, ses_ctrl
`timescale 1ns / 1ps

module encoder_speed_estimator import ses_pkg::*; #(
    parameter int MAX_SLOTS  = DEF_MAX_SLOTS,
    parameter int ANGLE_BITS = DEF_ANGLE_BITS
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    ses_in_if.sink                sample,
    ses_out_if.source             result
);

    localparam int CUR_W     = $clog2(MAX_SLOTS);
    localparam int CNT_W     = $clog2(MAX_SLOTS + 1);
    localparam int PROD_W    = GAIN_W + 1 + ANGLE_BITS;
    localparam int ALU_W     = SUM_W + 1;
    localparam int ITER_W    = $clog2(SUM_W);
    localparam int FLEN_INIT = (FLEN_RESET > MAX_SLOTS) ? MAX_SLOTS : FLEN_RESET;

    localparam logic signed [WIDE_W-1:0] SPD_HI = WIDE_W'(SPEED_MAX);
    localparam logic signed [WIDE_W-1:0] SPD_LO = WIDE_W'(SPEED_MIN);

    // configuration
    logic [GAIN_W-1:0] gain_reg;
    logic [CNT_W-1:0]  flen_reg;
    logic [FLEN_W-1:0] flen_raw;
    logic [CNT_W-1:0]  flen_wr;

    // estimator state
    logic                     first_reg;
    logic [ANGLE_BITS-1:0]    prev_angle_reg;
    logic [SPEED_W-1:0]       held_speed_reg;
    logic [SPEED_W-1:0]       held_avg_reg;
    logic [MAX_SLOTS-1:0]     written_reg;
    logic [MAX_SLOTS-1:0]     active_reg;
    logic [SUM_W-1:0]         sum_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [CUR_W-1:0]         cursor_reg;
    logic [ITER_W-1:0]        iter_reg;

    // working registers of one word
    status_t                  status_reg;
    logic signed [ANGLE_BITS-1:0] diff_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic [SPEED_W-1:0]       spd_reg;
    logic [SUM_W-1:0]         quot_reg;
    logic [CNT_W-1:0]         rem_reg;
    logic                     neg_reg;

    // result register
    logic                       out_valid_reg;
    logic [STATUS_W-1:0]        out_status_reg;
    logic [ANGLE_OUT_W-1:0]     out_angle_reg;
    logic [SPEED_W-1:0]         out_speed_reg;
    logic [SPEED_W-1:0]         out_avg_reg;

    ctrl_t   ctrl;
    fsm_in_t flags;

    logic                     take;
    logic                     bad_parity;
    logic [ANGLE_BITS-1:0]    angle_in;
    logic [ANGLE_BITS-1:0]    diff_next;
    logic [SPEED_W-1:0]       ram_rdata;
    logic [SPEED_W-1:0]       slot_val;
    logic signed [WIDE_W-1:0] prod_ext;
    logic signed [WIDE_W-1:0] spd_sh;
    logic [SPEED_W-1:0]       spd_next;
    logic [CNT_W:0]           cur_inc;
    logic [CNT_W:0]           trial;
    logic [ALU_W-1:0]         alu_a;
    logic [ALU_W-1:0]         alu_b;
    logic [ALU_W-1:0]         alu_y;
    alu_op_t                  alu_op;
    logic                     div_ge;
    logic                     diff_nz;

    assign take       = sample.valid && ctrl.ready;
    assign bad_parity = ^sample.raw_word;
    assign angle_in   = sample.raw_word[ANGLE_BITS-1:0];
    assign diff_next  = angle_in - prev_angle_reg;
    assign diff_nz    = (diff_reg != '0);
    assign slot_val   = written_reg[cursor_reg] ? ram_rdata : '0;

    // floor shift of the product, then clamp to the speed range
    assign prod_ext = {{(WIDE_W - PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
    assign spd_sh   = prod_ext >>> FRAC_SHIFT;

    always_comb
    begin
        if (spd_sh > SPD_HI)
        begin
            spd_next = SPD_HI[SPEED_W-1:0];
        end
        else if (spd_sh < SPD_LO)
        begin
            spd_next = SPD_LO[SPEED_W-1:0];
        end
        else
        begin
            spd_next = spd_sh[SPEED_W-1:0];
        end
    end

    assign cur_inc = (CNT_W + 1)'(cursor_reg) + (CNT_W + 1)'(1);
    assign trial   = {rem_reg, quot_reg[SUM_W-1]};

    always_comb
    begin
        flen_raw = cfg_data[FLEN_W-1:0];
        if (flen_raw == '0)
        begin
            flen_wr = CNT_W'(1);
        end
        else if (flen_raw > FLEN_W'(MAX_SLOTS))
        begin
            flen_wr = CNT_W'(MAX_SLOTS);
        end
        else
        begin
            flen_wr = CNT_W'(flen_raw);
        end
    end

    // operand select for the shared adder
    always_comb
    begin
        case (ctrl.sel)
            SEL_SLOT:
            begin
                alu_a  = {sum_reg[SUM_W-1], sum_reg};
                alu_b  = {{(ALU_W - SPEED_W){slot_val[SPEED_W-1]}}, slot_val};
                alu_op = ALU_SUB;
            end
            SEL_SPEED:
            begin
                alu_a  = {sum_reg[SUM_W-1], sum_reg};
                alu_b  = {{(ALU_W - SPEED_W){spd_reg[SPEED_W-1]}}, spd_reg};
                alu_op = ALU_ADD;
            end
            SEL_ABS:
            begin
                alu_a  = '0;
                alu_b  = {sum_reg[SUM_W-1], sum_reg};
                alu_op = sum_reg[SUM_W-1] ? ALU_SUB : ALU_ADD;
            end
            SEL_DIV:
            begin
                alu_a  = ALU_W'(trial);
                alu_b  = ALU_W'(count_reg);
                alu_op = ALU_SUB;
            end
            SEL_NEG:
            begin
                alu_a  = '0;
                alu_b  = {1'b0, quot_reg};
                alu_op = neg_reg ? ALU_SUB : ALU_ADD;
            end
            default:
            begin
                alu_a  = '0;
                alu_b  = '0;
                alu_op = ALU_ADD;
            end
        endcase
    end

    assign div_ge = !alu_y[ALU_W-1];

    ses_alu #(
        .WIDTH (ALU_W)
    ) u_alu (
        .a  (alu_a),
        .b  (alu_b),
        .op (alu_op),
        .y  (alu_y)
    );

    ses_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (MAX_SLOTS)
    ) u_ram (
        .clk   (clk),
        .we    (ctrl.upd_add && diff_nz),
        .waddr (cursor_reg),
        .wdata (spd_reg),
        .re    (take),
        .raddr (cursor_reg),
        .rdata (ram_rdata)
    );

    assign flags.in_valid   = sample.valid;
    assign flags.skip_math  = bad_parity || first_reg;
    assign flags.count_zero = (count_reg == '0);
    assign flags.div_last   = (iter_reg == ITER_W'(SUM_W - 1));
    assign flags.out_free   = !out_valid_reg || result.ready;

    ses_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .flags (flags),
        .ctrl  (ctrl)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg <= GAIN_RESET;
        end
        else if (cfg_we && cfg_index == CFG_GAIN)
        begin
            gain_reg <= cfg_data[GAIN_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            flen_reg       <= CNT_W'(FLEN_INIT);
            first_reg      <= 1'b1;
            prev_angle_reg <= '0;
            held_speed_reg <= '0;
            held_avg_reg   <= '0;
            written_reg    <= '0;
            active_reg     <= '1;
            sum_reg        <= '0;
            count_reg      <= CNT_W'(FLEN_INIT);
            cursor_reg     <= '0;
            iter_reg       <= '0;
        end
        else if (cfg_we && cfg_index == CFG_FLEN)
        begin
            // new length restarts the filter
            flen_reg       <= flen_wr;
            first_reg      <= 1'b1;
            prev_angle_reg <= '0;
            held_speed_reg <= '0;
            held_avg_reg   <= '0;
            written_reg    <= '0;
            active_reg     <= '1;
            sum_reg        <= '0;
            count_reg      <= flen_wr;
            cursor_reg     <= '0;
            iter_reg       <= '0;
        end
        else
        begin
            if (take && !bad_parity)
            begin
                prev_angle_reg <= angle_in;
                first_reg      <= 1'b0;
            end
            if (ctrl.upd_sub && active_reg[cursor_reg])
            begin
                sum_reg <= alu_y[SUM_W-1:0];
                if (count_reg != '0)
                begin
                    count_reg <= count_reg - CNT_W'(1);
                end
            end
            if (ctrl.upd_add)
            begin
                if (diff_nz)
                begin
                    sum_reg                 <= alu_y[SUM_W-1:0];
                    count_reg               <= count_reg + CNT_W'(1);
                    held_speed_reg          <= spd_reg;
                    written_reg[cursor_reg] <= 1'b1;
                    active_reg[cursor_reg]  <= 1'b1;
                end
                else
                begin
                    active_reg[cursor_reg] <= 1'b0;
                end
                if (cur_inc >= (CNT_W + 1)'(flen_reg))
                begin
                    cursor_reg <= '0;
                end
                else
                begin
                    cursor_reg <= cur_inc[CUR_W-1:0];
                end
            end
            if (ctrl.ld_abs)
            begin
                iter_reg <= '0;
            end
            else if (ctrl.div_step)
            begin
                iter_reg <= iter_reg + ITER_W'(1);
            end
            if (ctrl.ld_avg)
            begin
                held_avg_reg <= alu_y[SPEED_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            diff_reg <= diff_next;
            if (bad_parity)
            begin
                status_reg <= ST_PARITY;
            end
            else if (first_reg)
            begin
                status_reg <= ST_FIRST;
            end
            else
            begin
                status_reg <= ST_SPEED;
            end
        end
        if (ctrl.ld_prod)
        begin
            prod_reg <= $signed({1'b0, gain_reg}) * diff_reg;
        end
        if (ctrl.upd_sub)
        begin
            spd_reg <= spd_next;
        end
        if (ctrl.ld_abs)
        begin
            quot_reg <= alu_y[SUM_W-1:0];
            rem_reg  <= '0;
            neg_reg  <= sum_reg[SUM_W-1];
        end
        else if (ctrl.div_step)
        begin
            // restoring step: quotient bits shift in behind the dividend
            quot_reg <= {quot_reg[SUM_W-2:0], div_ge};
            rem_reg  <= div_ge ? alu_y[CNT_W-1:0] : trial[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (ctrl.ld_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.ld_out)
        begin
            out_status_reg <= status_reg;
            out_angle_reg  <= ANGLE_OUT_W'(prev_angle_reg);
            out_speed_reg  <= held_speed_reg;
            out_avg_reg    <= held_avg_reg;
        end
    end

    assign sample.ready             = ctrl.ready;
    assign result.valid             = out_valid_reg;
    assign result.status            = out_status_reg;
    assign result.angle             = out_angle_reg;
    assign result.speed_q5          = out_speed_reg;
    assign result.filtered_speed_q5 = out_avg_reg;

endmodule

### rtl/ses_chk.sv
// ses_chk: port-level checks of the encoder speed estimator, bound to the top level
// depends on ses_pkg and assert_macros.svh
`timescale 1ns / 1ps
`include "assert_macros.svh"

module ses_chk import ses_pkg::*; (
    input logic                clk,
    input logic                rst_n,
    input logic                in_valid,
    input logic                in_ready,
    input logic                out_valid,
    input logic                out_ready,
    input logic [STATUS_W-1:0] out_status
);

    // one word at a time: busy right after an accept
    `ASSERT_CLK(a_busy_after_accept, clk, rst_n, (in_valid && in_ready) |=> !in_ready, "ready after accept")

    // a new result only comes out of a busy cycle
    `ASSERT_CLK(a_result_from_work, clk, rst_n, $rose(out_valid) |-> $past(!in_ready), "result without work")

    // a stalled result word stays
    `ASSERT_CLK(a_out_hold, clk, rst_n, (out_valid && !out_ready) |=> out_valid, "result word dropped")

    `ASSERT_ALWAYS(a_status_code, clk, out_valid |-> (out_status == ST_SPEED || out_status == ST_PARITY || out_status == ST_FIRST), "bad status code")

endmodule

bind encoder_speed_estimator ses_chk u_ses_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (sample.valid),
    .in_ready   (sample.ready),
    .out_valid  (result.valid),
    .out_ready  (result.ready),
    .out_status (result.status)
);

### verif/encoder_speed_estimator_tb.sv
// encoder_speed_estimator_tb: randomized valid/ready testbench with a built-in speed predictor
// depends on ses_pkg, ses_if and the encoder_speed_estimator rtl
`timescale 1ns / 1ps

module encoder_speed_estimator_tb;
    import ses_pkg::*;

    localparam int IDLE_LIMIT = 4000;
    localparam int LONG_HOLD  = 800;
    localparam int TAIL_WAIT  = 50;
    localparam int PHASES     = 8;
    localparam int PHASE_WORDS = 230;

    typedef struct packed {
        status_t                   status;
        logic [ANGLE_OUT_W-1:0]    angle;
        logic signed [SPEED_W-1:0] speed_q5;
        logic signed [SPEED_W-1:0] filtered_speed_q5;
    } speed_result_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    ses_in_if  sample_ch ();
    ses_out_if result_ch ();

    encoder_speed_estimator i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    // predictor copy of the block state
    logic [GAIN_W-1:0]         gain;
    int                        flen;
    bit                        first_pending;
    logic [ANGLE_OUT_W-1:0]    prev_angle;
    logic signed [SPEED_W-1:0] held_speed;
    logic signed [SPEED_W-1:0] slot_speed [DEF_MAX_SLOTS];
    bit [DEF_MAX_SLOTS-1:0]    slot_active;
    int                        running_sum;
    int                        active_count;
    int                        ring_cursor;
    logic signed [SPEED_W-1:0] held_average;

    logic [WORD_W-1:0] word_queue [$];
    speed_result_t     speed_expected [$];

    int  words_offered = 0;
    int  words_taken = 0;
    int  idle_cycles = 0;
    int  fail_count = 0;
    int  send_gap = 0;
    int  hold_left = 0;
    int  next_long_hold = 500;
    bit  gaps_enabled = 1'b1;
    logic [ANGLE_OUT_W-1:0] walk_angle = '0;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic void restart_filter();
        first_pending = 1'b1;
        prev_angle    = '0;
        held_speed    = '0;
        for (int i = 0; i < DEF_MAX_SLOTS; i++)
            slot_speed[i] = '0;
        slot_active   = '1;
        running_sum   = 0;
        active_count  = flen;
        ring_cursor   = 0;
        held_average  = '0;
    endfunction

    function automatic speed_result_t predict_speed(logic [WORD_W-1:0] word);
        speed_result_t          r;
        logic [ANGLE_OUT_W-1:0] ang;
        logic [ANGLE_OUT_W-1:0] d;
        longint                 diff;
        longint                 g;
        longint                 spd;
        int                     c;
        r.status = ST_SPEED;
        if (^word)
        begin
            r.status = ST_PARITY;
        end
        else
        begin
            ang = word[ANGLE_OUT_W-1:0];
            if (first_pending)
            begin
                prev_angle    = ang;
                first_pending = 1'b0;
                r.status      = ST_FIRST;
            end
            else
            begin
                d          = ang - prev_angle;
                diff       = $signed(d);
                prev_angle = ang;
                c          = ring_cursor % DEF_MAX_SLOTS;
                if (slot_active[c])
                begin
                    running_sum -= slot_speed[c];
                    if (active_count > 0)
                        active_count--;
                end
                if (diff != 0)
                begin
                    g   = gain;
                    // arithmetic shift floors negative products
                    spd = (g * diff) >>> FRAC_SHIFT;
                    if (spd > SPEED_MAX)
                        spd = SPEED_MAX;
                    if (spd < SPEED_MIN)
                        spd = SPEED_MIN;
                    held_speed     = spd[SPEED_W-1:0];
                    slot_speed[c]  = held_speed;
                    running_sum   += held_speed;
                    active_count++;
                    slot_active[c] = 1'b1;
                end
                else
                begin
                    slot_speed[c]  = '0;
                    slot_active[c] = 1'b0;
                end
                c++;
                if (c >= flen)
                    c = 0;
                ring_cursor = c;
                if (active_count > 0)
                    held_average = SPEED_W'(running_sum / active_count);
            end
        end
        r.angle             = prev_angle;
        r.speed_q5          = held_speed;
        r.filtered_speed_q5 = held_average;
        return r;
    endfunction

    function automatic logic [WORD_W-1:0] good_word(logic [ANGLE_OUT_W-1:0] ang, bit top);
        return {top, top ^ (^ang), ang};
    endfunction

    function automatic logic [WORD_W-1:0] bad_word(logic [ANGLE_OUT_W-1:0] ang, bit top);
        return {top, ~(top ^ (^ang)), ang};
    endfunction

    // mostly a random walk of even-parity angles, with repeats and parity noise
    function automatic logic [WORD_W-1:0] random_word();
        int               r;
        int               step;
        logic [WORD_W-1:0] w;
        r = $urandom_range(0, 99);
        if (r < 8)
        begin
            w = WORD_W'($urandom);
            if (!(^w))
                w[14] = ~w[14];
            return w;
        end
        if (r < 18)
            return good_word(walk_angle, 1'($urandom_range(0, 1)));
        if (r < 23)
            walk_angle = ANGLE_OUT_W'($urandom);
        else
        begin
            step = (r < 75) ? $urandom_range(1, 64) : $urandom_range(1, 8192);
            if ($urandom_range(0, 1))
                step = -step;
            walk_angle = walk_angle + ANGLE_OUT_W'(step);
        end
        return good_word(walk_angle, 1'($urandom_range(0, 1)));
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    task automatic check_field(string name, longint exp_v, longint act_v);
        if (exp_v != act_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        int len;
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we    <= 1'b0;
        if (idx == CFG_GAIN)
        begin
            gain = data[GAIN_W-1:0];
        end
        else if (idx == CFG_FLEN)
        begin
            len = data[FLEN_W-1:0];
            if (len < 1)
                len = 1;
            if (len > DEF_MAX_SLOTS)
                len = DEF_MAX_SLOTS;
            flen = len;
            restart_filter();
        end
    endtask

    // block until every queued word went in and every result came back
    task automatic wait_drained();
        @(negedge clk);
        while (word_queue.size() != 0 || sample_ch.valid || speed_expected.size() != 0)
            @(negedge clk);
        repeat (40) @(negedge clk);
    endtask

    // sender: one word in flight, gap counted after it is taken
    always @(negedge clk)
    begin
        bit next_valid;
        if (rst_n)
        begin
            if (!(sample_ch.valid && words_taken != words_offered))
            begin
                next_valid = 1'b0;
                if (send_gap > 0)
                begin
                    send_gap--;
                end
                else if (word_queue.size() != 0)
                begin
                    sample_ch.raw_word <= word_queue.pop_front();
                    next_valid = 1'b1;
                    words_offered++;
                    send_gap = gaps_enabled ? pick_gap() : 0;
                end
                sample_ch.valid <= next_valid;
            end
        end
    end

    // receiver: random stalls plus a long hold-off now and then
    always @(negedge clk)
    begin
        bit rdy;
        if (rst_n)
        begin
            if (words_taken >= next_long_hold)
            begin
                hold_left = LONG_HOLD;
                next_long_hold += 900;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                rdy = 1'b0;
            end
            else if (gaps_enabled && $urandom_range(0, 99) < 20)
            begin
                hold_left = pick_gap();
                rdy = 1'b0;
            end
            else
            begin
                rdy = 1'b1;
            end
            result_ch.ready <= rdy;
        end
    end

    // check results first, then predict the word taken at the same edge
    always @(posedge clk)
    begin
        speed_result_t due;
        bit            moved;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_ch.valid && result_ch.ready)
            begin
                moved = 1'b1;
                if (speed_expected.size() == 0)
                begin
                    $error("result word with nothing expected");
                    fail_count++;
                end
                else
                begin
                    due = speed_expected.pop_front();
                    check_field("status", due.status, result_ch.status);
                    check_field("angle", due.angle, result_ch.angle);
                    check_field("speed_q5", due.speed_q5, result_ch.speed_q5);
                    check_field("filtered_speed_q5", due.filtered_speed_q5,
                                result_ch.filtered_speed_q5);
                end
            end
            if (sample_ch.valid && sample_ch.ready)
            begin
                moved = 1'b1;
                speed_expected.push_back(predict_speed(sample_ch.raw_word));
                words_taken++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial
    begin
        wait (idle_cycles >= IDLE_LIMIT);
        $display("** encoder_speed_estimator: FAILED **");
        $finish;
    end

    initial
    begin
        int flen_code [PHASES];
        logic [CFG_DATA_W-1:0] gain_val;
        logic [CFG_DATA_W-1:0] flen_val;
        flen_code = '{32, 63, 1, 33, 2, 0, 20, 0};
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = CFG_GAIN;
        cfg_data           = '0;
        sample_ch.valid    = 1'b0;
        sample_ch.raw_word = '0;
        result_ch.ready    = 1'b0;
        gain               = GAIN_RESET;
        flen               = FLEN_RESET;
        restart_filter();
        repeat (6) @(negedge clk);
        rst_n = 1'b1;

        // reset settings: parity before the first sample, wraps and both diff extremes
        @(posedge clk);
        word_queue.push_back(bad_word(0, 0));
        word_queue.push_back(good_word(100, 0));
        word_queue.push_back(good_word(100, 1));
        word_queue.push_back(good_word(101, 0));
        word_queue.push_back(good_word(100, 0));
        word_queue.push_back(good_word(0, 1));
        word_queue.push_back(good_word(16383, 0));
        word_queue.push_back(good_word(8191, 1));
        word_queue.push_back(good_word(0, 0));
        word_queue.push_back(good_word(8191, 0));
        word_queue.push_back(bad_word(16383, 1));
        word_queue.push_back(16'hFFFF);
        word_queue.push_back(16'h0000);
        wait_drained();

        // full-scale gain gives the speed extremes
        write_register(CFG_GAIN, 24'hFFFFFF);
        @(posedge clk);
        word_queue.push_back(good_word(0, 0));
        word_queue.push_back(good_word(8192, 0));
        word_queue.push_back(good_word(8191, 1));
        word_queue.push_back(good_word(0, 1));
        word_queue.push_back(good_word(8191, 0));
        wait_drained();

        // zero gain: slots active but holding zero
        write_register(CFG_GAIN, '0);
        @(posedge clk);
        word_queue.push_back(good_word(5, 0));
        word_queue.push_back(good_word(5000, 1));
        wait_drained();

        // length 0 is taken as one slot
        write_register(CFG_GAIN, GAIN_RESET);
        write_register(CFG_FLEN, '0);
        @(posedge clk);
        word_queue.push_back(good_word(10, 0));
        word_queue.push_back(good_word(20, 0));
        word_queue.push_back(good_word(20, 1));
        word_queue.push_back(good_word(30, 0));
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: gain_val = 24'hFFFFFF;
                4: gain_val = 24'd1;
                6: gain_val = {8'd0, GAIN_RESET[15:0]};
                default: gain_val = CFG_DATA_W'($urandom);
            endcase
            flen_val = (flen_code[p] != 0) ? CFG_DATA_W'(flen_code[p])
                                           : CFG_DATA_W'($urandom_range(1, DEF_MAX_SLOTS));
            // junk above the length field on odd phases
            if (p % 2 == 1)
                flen_val[CFG_DATA_W-1:FLEN_W] = (CFG_DATA_W - FLEN_W)'($urandom);
            write_register(CFG_GAIN, gain_val);
            write_register(CFG_FLEN, flen_val);
            @(posedge clk);
            gaps_enabled = (p != 2);
            for (int i = 0; i < PHASE_WORDS; i++)
                word_queue.push_back(random_word());
            wait_drained();
        end

        repeat (TAIL_WAIT) @(posedge clk);
        if (speed_expected.size() != 0)
        begin
            $error("%0d result words never arrived", speed_expected.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("** encoder_speed_estimator: PASSED **");
        else
            $display("** encoder_speed_estimator: FAILED **");
        $finish;
    end

endmodule

### filelist.f
+incdir+rtl
rtl/ses_pkg.sv
rtl/ses_if.sv
rtl/ses_ram.sv
rtl/ses_alu.sv
rtl/ses_ctrl.sv
rtl/encoder_speed_estimator.sv
rtl/ses_chk.sv
verif/encoder_speed_estimator_tb.sv
